// ===== rtl/rsbn_pkg.sv =====
`default_nettype none

package rsbn_pkg;

   // store capacity and the widths that follow from it
   localparam int MAX_RECORDS = 16;
   localparam int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

   // name key: 30 bytes, first character in the top byte
   localparam int NAME_BYTES = 30;
   localparam int NAME_W     = 8 * NAME_BYTES;

   // one record; packed so that the first field sits in the highest bits
   typedef struct packed {
      logic [63:0] height_bits;
      logic [63:0] weight_bits;
      logic [7:0]  age_value;
      logic [47:0] key_d;
      logic [63:0] key_c;
      logic [63:0] key_b;
      logic [63:0] key_a;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // record store port controls
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic             re;
      logic [IDX_W-1:0] raddr_a;
      logic [IDX_W-1:0] raddr_b;
   } mem_ctl_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PREP,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_WR_A,
      ST_SORT_WR_B,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/record_sort_by_name.sv =====
// record_sort_by_name: collects records and returns them sorted by name
//
// req_ carries one record per transaction; req_tlast closes the set. While
// the set is collected each accepted record is stored. Records beyond the
// store capacity are dropped and every result of that set has rsp_tuser set.
// On the closing record the set is bubble-sorted in place with one name
// comparator and one record store (one write port, two read ports).
// Each compare reads a neighbouring pair and compares it, and a swap writes
// both records back into the store; after the sort each result is read from
// the store and sent on the rsp_ side. req_tready is low from the
// closing record until the last result has entered the output register.
// Results leave through an output register: a stalled rsp_tready holds the
// transaction on rsp_ and the next result waits behind it. The next set may
// be taken while the final result still waits on rsp_.
// Reset (synchronous) empties the store and clears the overflow mark; the
// block is ready in the first cycle after reset.
`default_nettype none

module record_sort_by_name (
   input  wire logic         clock,
   input  wire logic         reset,
   // name_bytes_0_7, name_bytes_8_15, name_bytes_16_23, name_bytes_24_29,
   // age_value, weight_bits, height_bits
   input  wire logic [375:0] req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // out_name_0_7, out_name_8_15, out_name_16_23, out_name_24_29,
   // out_age, out_weight, out_height
   output logic [375:0]      rsp_tdata,
   output logic              rsp_tlast,
   // overflow_flag
   output logic              rsp_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready
);
   import rsbn_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] bound_ff, bound_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic             swapped_ff, swapped_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rec_type          rsp_rec_ff, rsp_rec_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   mem_ctl_type      mem_ctl;
   rec_type          mem_wdata;
   rec_type          rd_a;
   rec_type          rd_b;
   logic             a_after_b;

   logic             req_fire;
   logic             store_full;
   logic             more_in_pass;
   logic             pass_more;
   logic             out_free;
   logic             k_last;
   logic             rsp_load;

   // record store and the shared comparator
   rsbn_mem u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wdata   (mem_wdata),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   rsbn_cmp u_cmp (
      .rec_a     (rd_a),
      .rec_b     (rd_b),
      .a_after_b (a_after_b)
   );

   // status terms
   assign req_tready   = (state_ff == ST_LOAD);
   assign req_fire     = req_tvalid && req_tready;
   assign store_full   = (count_ff >= CNT_W'(MAX_RECORDS));
   assign more_in_pass = ((i_ff + IDX_W'(1)) < bound_ff);
   assign pass_more    = swapped_ff && (last_ff != '0);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign k_last       = ((CNT_W'(k_ff) + CNT_W'(1)) == count_ff);
   assign rsp_load     = (state_ff == ST_EMIT_OUT) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_tlast) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (count_ff == '0) begin
               state_in = ST_LOAD;
            end else if (count_ff < CNT_W'(2)) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_SORT_RD;
            end
         end
         ST_SORT_RD: begin
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            if (a_after_b) begin
               state_in = ST_SORT_WR_A;
            end else if (more_in_pass || pass_more) begin
               state_in = ST_SORT_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_SORT_WR_A: begin
            state_in = ST_SORT_WR_B;
         end
         ST_SORT_WR_B: begin
            if (more_in_pass || pass_more) begin
               state_in = ST_SORT_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               state_in = k_last ? ST_LOAD : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // datapath and store controls
   always_comb begin
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      i_in           = i_ff;
      bound_in       = bound_ff;
      last_in        = last_ff;
      swapped_in     = swapped_ff;
      k_in           = k_ff;
      mem_ctl        = '0;
      mem_wdata      = rec_type'(req_tdata);
      mem_ctl.raddr_a = i_ff;
      mem_ctl.raddr_b = i_ff + IDX_W'(1);

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (!store_full) begin
                  mem_ctl.we    = 1'b1;
                  mem_ctl.waddr = count_ff[IDX_W-1:0];
                  count_in      = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         ST_PREP: begin
            bound_in   = IDX_W'(count_ff - CNT_W'(1));
            i_in       = '0;
            last_in    = '0;
            swapped_in = 1'b0;
            k_in       = '0;
            if (count_ff == '0) begin
               dropped_in = 1'b0;
            end
         end
         ST_SORT_RD: begin
            mem_ctl.re = 1'b1;
         end
         ST_SORT_CMP: begin
            if (a_after_b) begin
               last_in    = i_ff;
               swapped_in = 1'b1;
            end else if (more_in_pass) begin
               i_in = i_ff + IDX_W'(1);
            end else begin
               // start of the next, shorter pass
               i_in       = '0;
               bound_in   = last_ff;
               last_in    = '0;
               swapped_in = 1'b0;
            end
         end
         ST_SORT_WR_A: begin
            mem_ctl.we    = 1'b1;
            mem_ctl.waddr = i_ff;
            mem_wdata     = rd_b;
         end
         ST_SORT_WR_B: begin
            mem_ctl.we    = 1'b1;
            mem_ctl.waddr = i_ff + IDX_W'(1);
            mem_wdata     = rd_a;
            if (more_in_pass) begin
               i_in = i_ff + IDX_W'(1);
            end else begin
               i_in       = '0;
               bound_in   = last_ff;
               last_in    = '0;
               swapped_in = 1'b0;
            end
         end
         ST_EMIT_RD: begin
            mem_ctl.re      = 1'b1;
            mem_ctl.raddr_a = k_ff;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               if (k_last) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
               end else begin
                  k_in = k_ff + IDX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_rec_in   = rd_a;
         rsp_last_in  = k_last;
         rsp_ovf_in   = dropped_ff;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         i_ff         <= '0;
         bound_ff     <= '0;
         last_ff      <= '0;
         swapped_ff   <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         i_ff         <= i_in;
         bound_ff     <= bound_in;
         last_ff      <= last_in;
         swapped_ff   <= swapped_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_rec_ff  <= rsp_rec_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tdata  = rsp_rec_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // store fill never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECORDS))
      else $error("record count beyond capacity");

   // records are only dropped once the store is full
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> (count_ff == CNT_W'(MAX_RECORDS)))
      else $error("overflow marked with room left");

   // compare positions stay inside the current pass
   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT_RD) |-> ((i_ff < bound_ff) && (CNT_W'(bound_ff) < count_ff)))
      else $error("compare position outside pass");

   // a swap writes both neighbours in consecutive cycles
   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT_WR_A) |=> (state_ff == ST_SORT_WR_B) && $stable(i_ff))
      else $error("swap not completed");

   // the final result of a set returns the block to collecting
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && k_last) |=> ((state_ff == ST_LOAD) && (count_ff == '0) && rsp_tlast))
      else $error("set not closed after final result");

endmodule

`default_nettype wire

// ===== rtl/rsbn_mem.sv =====
`default_nettype none

module rsbn_mem (
   input  wire logic                 clock,
   input  wire rsbn_pkg::mem_ctl_type ctl,
   input  wire rsbn_pkg::rec_type    wdata,
   output rsbn_pkg::rec_type         rdata_a,
   output rsbn_pkg::rec_type         rdata_b
);
   import rsbn_pkg::*;

   rec_type mem [MAX_RECORDS];
   rec_type rdata_a_ff;
   rec_type rdata_b_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= wdata;
      end
   end

   // two registered read ports, data held while no read is issued
   always_ff @(posedge clock) begin
      if (ctl.re) begin
         rdata_a_ff <= mem[ctl.raddr_a];
         rdata_b_ff <= mem[ctl.raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// ===== rtl/rsbn_cmp.sv =====
`default_nettype none

module rsbn_cmp (
   input  wire rsbn_pkg::rec_type rec_a,
   input  wire rsbn_pkg::rec_type rec_b,
   output logic                   a_after_b
);
   import rsbn_pkg::*;

   logic [NAME_W-1:0]     name_a;
   logic [NAME_W-1:0]     name_b;
   logic [NAME_BYTES-1:0] stop;
   logic [NAME_BYTES-1:0] greater;
   logic [NAME_BYTES-1:0] first;

   assign name_a = {rec_a.key_a, rec_a.key_b, rec_a.key_c, rec_a.key_d};
   assign name_b = {rec_b.key_a, rec_b.key_b, rec_b.key_c, rec_b.key_d};

   // per byte: a difference or a terminating zero decides the order
   always_comb begin
      for (int k = 0; k < NAME_BYTES; k++) begin
         stop[k]    = (name_a[NAME_W-1-8*k -: 8] != name_b[NAME_W-1-8*k -: 8])
                      || (name_a[NAME_W-1-8*k -: 8] == 8'd0);
         greater[k] = name_a[NAME_W-1-8*k -: 8] > name_b[NAME_W-1-8*k -: 8];
      end
   end

   // earliest deciding byte, character 0 first
   assign first     = stop & (~stop + NAME_BYTES'(1));
   assign a_after_b = |(first & greater);

endmodule

`default_nettype wire

// ===== bench/tb_record_sort_by_name.sv =====
`timescale 1ns / 1ps

import rsbn_pkg::*;

// one expected result: the record plus its end-of-run and overflow marks
typedef struct {
   rec_type rec;
   bit      run_end;
   bit      overflow;
} sorted_entry_type;

class name_sort_scoreboard;
   rec_type          held[$];
   bit               dropped;
   sorted_entry_type sorted_q[$];
   int               errors;

   function new();
      dropped = 0;
      errors  = 0;
   endfunction

   // whole name with char 0 in the top byte
   function logic [239:0] full_name(rec_type r);
      return {r.key_a, r.key_b, r.key_c, r.key_d};
   endfunction

   // true when the name of a belongs strictly after the name of b
   function bit name_after(rec_type a, rec_type b);
      logic [239:0] na, nb;
      logic [7:0]   x, y;
      na = full_name(a);
      nb = full_name(b);
      for (int k = 0; k < NAME_BYTES; k++) begin
         x = na[239 - 8 * k -: 8];
         y = nb[239 - 8 * k -: 8];
         if (x != y)
            return x > y;
         // a zero byte ends both names here
         if (x == 8'h00)
            return 0;
      end
      return 0;
   endfunction

   // stable bubble sort, each pass ends at the previous last swap
   function void sort_held();
      int      bound, last_swap;
      bit      swapped;
      rec_type tmp;
      if (held.size() < 2)
         return;
      bound = held.size() - 1;
      do begin
         swapped   = 0;
         last_swap = 0;
         for (int i = 0; i < bound; i++) begin
            if (name_after(held[i], held[i + 1])) begin
               tmp         = held[i];
               held[i]     = held[i + 1];
               held[i + 1] = tmp;
               last_swap   = i;
               swapped     = 1;
            end
         end
         bound = last_swap;
      end while (swapped);
   endfunction

   // accepted input transaction
   function void note_record(rec_type r, bit closes_set);
      sorted_entry_type e;
      if (held.size() < MAX_RECORDS)
         held.push_back(r);
      else
         dropped = 1;
      if (!closes_set)
         return;
      sort_held();
      foreach (held[k]) begin
         e.rec      = held[k];
         e.run_end  = (k == held.size() - 1);
         e.overflow = dropped;
         sorted_q.push_back(e);
      end
      held.delete();
      dropped = 0;
   endfunction

   function void check_field(string fld, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", fld, want, got);
         errors++;
      end
   endfunction

   // accepted result transaction
   function void check_result(rec_type got, bit got_end, bit got_over);
      sorted_entry_type want;
      if (sorted_q.size() == 0) begin
         $error("result transaction with nothing outstanding: name %h",
                full_name(got));
         errors++;
         return;
      end
      want = sorted_q.pop_front();
      check_field("out_name_0_7", want.rec.key_a, got.key_a);
      check_field("out_name_8_15", want.rec.key_b, got.key_b);
      check_field("out_name_16_23", want.rec.key_c, got.key_c);
      check_field("out_name_24_29", 64'(want.rec.key_d), 64'(got.key_d));
      check_field("out_age", 64'(want.rec.age_value), 64'(got.age_value));
      check_field("out_weight", want.rec.weight_bits, got.weight_bits);
      check_field("out_height", want.rec.height_bits, got.height_bits);
      check_field("out_last", 64'(want.run_end), 64'(got_end));
      check_field("overflow_flag", 64'(want.overflow), 64'(got_over));
   endfunction
endclass

module tb_record_sort_by_name;

   logic         clock;
   logic         reset;
   logic [375:0] req_tdata;
   logic         req_tlast;
   logic         req_tvalid;
   logic         req_tready;
   logic [375:0] rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;

   name_sort_scoreboard sb = new();
   bit                  calm_stretch;

   record_sort_by_name dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [239:0] name_of(string s);
      logic [239:0] nm;
      nm = '0;
      for (int k = 0; k < s.len() && k < NAME_BYTES; k++)
         nm[239 - 8 * k -: 8] = s[k];
      return nm;
   endfunction

   // random name: mostly short names over a few letters so that ties and
   // shared prefixes are common, sometimes full byte range or no terminator
   function automatic logic [239:0] random_name();
      logic [239:0] nm;
      int           len;
      bit           wide, junk;
      nm   = '0;
      wide = ($urandom_range(0, 3) == 0);
      junk = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 7))
         0:       len = NAME_BYTES;
         1, 2:    len = $urandom_range(0, NAME_BYTES - 1);
         default: len = $urandom_range(0, 5);
      endcase
      for (int k = 0; k < NAME_BYTES; k++) begin
         if (k < len)
            nm[239 - 8 * k -: 8] = wide ? 8'($urandom_range(1, 255))
                                        : 8'($urandom_range(97, 100));
         else if (k > len && junk)
            nm[239 - 8 * k -: 8] = 8'($urandom_range(0, 255));
      end
      return nm;
   endfunction

   function automatic rec_type make_record(logic [239:0] nm);
      rec_type r;
      r.key_a       = nm[239:176];
      r.key_b       = nm[175:112];
      r.key_c       = nm[111:48];
      r.key_d       = nm[47:0];
      r.age_value   = 8'($urandom_range(0, 255));
      r.weight_bits = {$urandom, $urandom};
      r.height_bits = {$urandom, $urandom};
      return r;
   endfunction

   // one input transaction, with random idle cycles ahead of it
   task automatic send_record(input rec_type r, input bit closes_set);
      if (!calm_stretch) begin
         while ($urandom_range(0, 99) < 33) begin
            req_tvalid = 0;
            @(negedge clock);
         end
      end
      req_tdata  = r;
      req_tlast  = closes_set;
      req_tvalid = 1;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_record(r, closes_set);
      @(negedge clock);
   endtask

   task automatic send_random_set(input int count);
      for (int k = 0; k < count; k++)
         send_record(make_record(random_name()), k == count - 1);
   endtask

   task automatic wait_all_sorted();
      while (sb.sorted_q.size() != 0)
         @(negedge clock);
   endtask

   // result side: random back-pressure and one long hold-off
   initial begin
      int seen;
      int hold_left;
      bit held_once;
      seen       = 0;
      hold_left  = 0;
      held_once  = 0;
      rsp_tready = 0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         if (hold_left > 0) begin
            rsp_tready = 0;
            hold_left--;
         end else if (!held_once && seen >= 40) begin
            held_once  = 1;
            hold_left  = 600;
            rsp_tready = 0;
         end else begin
            rsp_tready = calm_stretch || ($urandom_range(0, 99) >= 33);
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rec_type'(rsp_tdata), rsp_tlast, rsp_tuser);
            seen++;
         end
         @(negedge clock);
      end
   end

   // input side
   initial begin
      rec_type      r;
      logic [239:0] nm;
      int           sent;
      int           set_size;
      int           pick;
      reset        = 1;
      req_tdata    = '0;
      req_tlast    = 0;
      req_tvalid   = 0;
      calm_stretch = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // single record set with every field at its maximum
      r = '1;
      send_record(r, 1);

      // ties, prefixes, top byte values and names without a terminator
      send_record('0, 0);
      send_record(make_record(name_of("bob")), 0);
      send_record(make_record(name_of("alice")), 0);
      nm = name_of("alice");
      nm[239 - 8 * 6 -: 8] = 8'hff;
      nm[7:0] = 8'h5a;
      send_record(make_record(nm), 0);
      send_record(make_record('1), 0);
      nm = '1;
      nm[7:0] = 8'hfe;
      send_record(make_record(nm), 0);
      send_record(make_record(name_of("alicf")), 0);
      send_record(make_record(name_of("al")), 1);

      // full store, the closing record itself is dropped
      send_random_set(MAX_RECORDS + 1);

      // sender waits for every outstanding result
      req_tvalid = 0;
      wait_all_sorted();

      // random sets, mostly small, some past capacity
      sent = 0;
      while (sent < 190) begin
         calm_stretch = (sent >= 60 && sent < 120);
         pick = $urandom_range(0, 99);
         if (pick < 65)
            set_size = $urandom_range(1, 5);
         else if (pick < 90)
            set_size = $urandom_range(6, MAX_RECORDS);
         else
            set_size = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
         send_random_set(set_size);
         sent += set_size;
      end
      calm_stretch = 0;
      req_tvalid   = 0;
      req_tlast    = 0;

      // drain and allow for stray results
      wait_all_sorted();
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
